FILE: hdl/tlrs_pkg.sv
// ----------------------------------------------------------------------------
// tlrs_pkg
// shared constants, types and codes for the trie edit-distance row step core
// ----------------------------------------------------------------------------
package tlrs_pkg;

	localparam int MAX_WORD    = 16;
	localparam int MAX_DEPTH   = 32;
	localparam int ROW_COLS    = MAX_WORD + 1;
	localparam int STACK_DEPTH = MAX_DEPTH * ROW_COLS;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int COL_W       = $clog2(ROW_COLS);
	localparam int CHAR_IDX_W  = $clog2(MAX_WORD);
	localparam int VAL_W       = 6;
	localparam int DEPTH_W     = 6;
	localparam int LEN_W       = 5;
	localparam int CHAR_W      = 8;
	localparam int QWORD_W     = 64;
	localparam int CFG_IDX_W   = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUERY_LOW  = 2'd0,
		CFG_QUERY_HIGH = 2'd1,
		CFG_QUERY_LEN  = 2'd2,
		CFG_LIMIT      = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_COLS,
		ST_FLUSH
	} seq_state_t;

	// per-cycle control from the sequencer to the column unit
	typedef struct packed {
		logic first;
		logic step;
		logic mismatch;
	} tlrs_ctrl_t;

endpackage

FILE: hdl/tlrs_ram.sv
// ----------------------------------------------------------------------------
// tlrs_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module tlrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/tlrs_col_unit.sv
// ----------------------------------------------------------------------------
// tlrs_col_unit
// shared column unit: one edit-distance cell per cycle plus running minimum
// ----------------------------------------------------------------------------
module tlrs_col_unit (
	input  logic                       clk,
	input  tlrs_pkg::tlrs_ctrl_t       ctrl,
	input  logic [tlrs_pkg::VAL_W-1:0] prev_val,
	output logic [tlrs_pkg::VAL_W-1:0] col_val,
	output logic [tlrs_pkg::VAL_W-1:0] curr_q,
	output logic [tlrs_pkg::VAL_W-1:0] min_q
);

	logic [tlrs_pkg::VAL_W-1:0] prev_last_q;
	logic [tlrs_pkg::VAL_W:0]   ins_w;
	logic [tlrs_pkg::VAL_W:0]   del_w;
	logic [tlrs_pkg::VAL_W:0]   sub_w;
	logic [tlrs_pkg::VAL_W:0]   best_w;
	logic [tlrs_pkg::VAL_W-1:0] min_next;

	always_comb begin
		ins_w  = {1'b0, curr_q} + (tlrs_pkg::VAL_W+1)'(1);
		del_w  = {1'b0, prev_val} + (tlrs_pkg::VAL_W+1)'(1);
		sub_w  = {1'b0, prev_last_q} + (tlrs_pkg::VAL_W+1)'(ctrl.mismatch);
		best_w = (ins_w < del_w) ? ins_w : del_w;
		if (sub_w < best_w) begin
			best_w = sub_w;
		end
		// column 0 is just one more than the parent's column 0
		if (ctrl.first) begin
			best_w = del_w;
		end
		col_val  = best_w[tlrs_pkg::VAL_W-1:0];
		min_next = (ctrl.first || (col_val < min_q)) ? col_val : min_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			prev_last_q <= prev_val;
			curr_q      <= col_val;
			min_q       <= min_next;
		end
	end

endmodule

FILE: hdl/tlrs_seq.sv
// ----------------------------------------------------------------------------
// tlrs_seq
// sequencer: walks the columns of one row, drives row stack addresses
// ----------------------------------------------------------------------------
module tlrs_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tlrs_pkg::DEPTH_W-1:0]   depth,
	input  logic [tlrs_pkg::CHAR_W-1:0]    letter,
	input  logic [tlrs_pkg::QWORD_W-1:0]   query_low,
	input  logic [tlrs_pkg::QWORD_W-1:0]   query_high,
	input  logic [tlrs_pkg::LEN_W-1:0]     query_len,
	input  logic                           out_free,
	input  logic [tlrs_pkg::VAL_W-1:0]     rd_data,
	output logic                           busy,
	output logic                           load,
	output logic                           rd_en,
	output logic [tlrs_pkg::ADDR_W-1:0]    rd_addr,
	output logic                           wr_en,
	output logic [tlrs_pkg::ADDR_W-1:0]    wr_addr,
	output tlrs_pkg::tlrs_ctrl_t           ctrl,
	output logic [tlrs_pkg::VAL_W-1:0]     prev_val
);

	tlrs_pkg::seq_state_t state_q, state_d;

	logic [tlrs_pkg::COL_W-1:0]    col_q;
	logic [tlrs_pkg::COL_W-1:0]    n_q;
	logic [tlrs_pkg::ADDR_W-1:0]   rd_base_q;
	logic [tlrs_pkg::ADDR_W-1:0]   wr_base_q;
	logic                          init_q;
	logic [tlrs_pkg::CHAR_W-1:0]   letter_q;

	logic [tlrs_pkg::DEPTH_W-1:0]  depth_sat;
	logic [tlrs_pkg::COL_W-1:0]    n_sat;
	logic [tlrs_pkg::COL_W-1:0]    rd_col;
	logic [tlrs_pkg::COL_W-1:0]    char_col;
	logic [2*tlrs_pkg::QWORD_W-1:0] query_vec;
	logic [tlrs_pkg::CHAR_W-1:0]   query_char;
	logic                          last_col;

	always_comb begin
		if (depth == '0) begin
			depth_sat = tlrs_pkg::DEPTH_W'(1);
		end else if (depth > tlrs_pkg::DEPTH_W'(tlrs_pkg::MAX_DEPTH)) begin
			depth_sat = tlrs_pkg::DEPTH_W'(tlrs_pkg::MAX_DEPTH);
		end else begin
			depth_sat = depth;
		end
		if (query_len == '0) begin
			n_sat = tlrs_pkg::COL_W'(1);
		end else if (query_len > tlrs_pkg::LEN_W'(tlrs_pkg::MAX_WORD)) begin
			n_sat = tlrs_pkg::COL_W'(tlrs_pkg::MAX_WORD);
		end else begin
			n_sat = tlrs_pkg::COL_W'(query_len);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q      <= n_sat;
			init_q   <= (depth_sat == tlrs_pkg::DEPTH_W'(1));
			letter_q <= letter;
			// parent row sits at depth-2, the new row at depth-1
			rd_base_q <= tlrs_pkg::ADDR_W'(depth_sat - tlrs_pkg::DEPTH_W'(2))
				* tlrs_pkg::ADDR_W'(tlrs_pkg::ROW_COLS);
			wr_base_q <= tlrs_pkg::ADDR_W'(depth_sat - tlrs_pkg::DEPTH_W'(1))
				* tlrs_pkg::ADDR_W'(tlrs_pkg::ROW_COLS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlrs_pkg::ST_IDLE;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				col_q <= '0;
			end else if (state_q == tlrs_pkg::ST_COLS && !last_col) begin
				col_q <= col_q + tlrs_pkg::COL_W'(1);
			end
		end
	end

	always_comb begin
		query_vec  = {query_high, query_low};
		char_col   = col_q - tlrs_pkg::COL_W'(1);
		query_char = query_vec[{char_col[tlrs_pkg::CHAR_IDX_W-1:0], 3'b000} +: tlrs_pkg::CHAR_W];
		last_col   = (col_q == n_q);
		rd_col     = (state_q == tlrs_pkg::ST_PRIME) ? col_q : col_q + tlrs_pkg::COL_W'(1);
		rd_addr    = rd_base_q + tlrs_pkg::ADDR_W'(rd_col);
		wr_addr    = wr_base_q + tlrs_pkg::ADDR_W'(col_q);
		prev_val   = init_q ? tlrs_pkg::VAL_W'(col_q) : rd_data;

		state_d       = state_q;
		busy          = 1'b1;
		load          = 1'b0;
		rd_en         = 1'b0;
		wr_en         = 1'b0;
		ctrl.first    = (col_q == '0);
		ctrl.step     = 1'b0;
		ctrl.mismatch = (query_char != letter_q);

		case (state_q)
			tlrs_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = tlrs_pkg::ST_PRIME;
				end
			end
			tlrs_pkg::ST_PRIME: begin
				rd_en   = !init_q;
				state_d = tlrs_pkg::ST_COLS;
			end
			tlrs_pkg::ST_COLS: begin
				ctrl.step = 1'b1;
				wr_en     = 1'b1;
				rd_en     = !init_q && !last_col;
				if (last_col) begin
					state_d = tlrs_pkg::ST_FLUSH;
				end
			end
			tlrs_pkg::ST_FLUSH: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = tlrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tlrs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/trie_levenshtein_row_step_core.sv
// ----------------------------------------------------------------------------
// trie_levenshtein_row_step_core
// edit-distance row step for a depth-first trie walk against a query word
// ----------------------------------------------------------------------------
// usage:
//   write the query characters, query length and distance limit through the
//   cfg channel (always ready) while no node request is in flight.
//   each node request carries depth, letter and end-of-word flag; the block
//   reads the parent row from the row stack (or uses 0..n at depth one),
//   stores the new row at the node's depth and returns one result request
//   with the last column, the row minimum and the match and descend flags.
//   parents must be visited before their children.
// operation:
//   with n the clipped query length, the column loop walks columns 0..n,
//   one column per cycle through the shared column unit, after a prime
//   state that starts the row stack read; a flush state then waits until
//   the result register is free and hands the row off, and the block goes
//   back to idle, where the next node request is taken. a new node is not
//   taken while a row is still being built.
// reset and stall:
//   reset clears the handshake state, the sequencer state and the cfg
//   registers to their defaults; the row stack, the result data and the
//   per-node registers are not cleared. a stalled result holds in its
//   register, and the block finishes the next row but waits to hand it off.
module trie_levenshtein_row_step_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tlrs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tlrs_pkg::QWORD_W-1:0]      cfg_data,
	input  logic                              node_valid,
	output logic                              node_stall,
	input  logic [tlrs_pkg::DEPTH_W-1:0]      node_depth,
	input  logic [tlrs_pkg::CHAR_W-1:0]       node_letter,
	input  logic                              node_ends_word,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [tlrs_pkg::VAL_W-1:0]        edit_distance,
	output logic                              is_match,
	output logic                              descend,
	output logic [tlrs_pkg::VAL_W-1:0]        row_minimum
);

	logic [tlrs_pkg::QWORD_W-1:0] query_low_q;
	logic [tlrs_pkg::QWORD_W-1:0] query_high_q;
	logic [tlrs_pkg::LEN_W-1:0]   query_len_q;
	logic [tlrs_pkg::VAL_W-1:0]   limit_q;

	logic                         ends_q;
	logic                         result_valid_q;
	logic [tlrs_pkg::VAL_W-1:0]   edit_distance_q;
	logic                         is_match_q;
	logic                         descend_q;
	logic [tlrs_pkg::VAL_W-1:0]   row_minimum_q;

	logic                         start;
	logic                         busy;
	logic                         load;
	logic                         out_free;
	logic                         rd_en;
	logic [tlrs_pkg::ADDR_W-1:0]  rd_addr;
	logic [tlrs_pkg::VAL_W-1:0]   rd_data;
	logic                         wr_en;
	logic [tlrs_pkg::ADDR_W-1:0]  wr_addr;
	tlrs_pkg::tlrs_ctrl_t         ctrl;
	logic [tlrs_pkg::VAL_W-1:0]   prev_val;
	logic [tlrs_pkg::VAL_W-1:0]   col_val;
	logic [tlrs_pkg::VAL_W-1:0]   curr_val;
	logic [tlrs_pkg::VAL_W-1:0]   min_val;

	assign cfg_ready  = 1'b1;
	assign node_stall = busy;
	assign start      = node_valid && !busy;
	assign out_free   = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_low_q  <= '0;
			query_high_q <= '0;
			query_len_q  <= tlrs_pkg::LEN_W'(1);
			limit_q      <= tlrs_pkg::VAL_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (tlrs_pkg::cfg_idx_t'(cfg_index))
				tlrs_pkg::CFG_QUERY_LOW:  query_low_q  <= cfg_data;
				tlrs_pkg::CFG_QUERY_HIGH: query_high_q <= cfg_data;
				tlrs_pkg::CFG_QUERY_LEN:  query_len_q  <= cfg_data[tlrs_pkg::LEN_W-1:0];
				tlrs_pkg::CFG_LIMIT:      limit_q      <= cfg_data[tlrs_pkg::VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ends_q <= node_ends_word;
		end
		if (load) begin
			edit_distance_q <= curr_val;
			row_minimum_q   <= min_val;
			is_match_q      <= ends_q && (curr_val <= limit_q);
			descend_q       <= (min_val <= limit_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid  = result_valid_q;
	assign edit_distance = edit_distance_q;
	assign is_match      = is_match_q;
	assign descend       = descend_q;
	assign row_minimum   = row_minimum_q;

	tlrs_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.depth      (node_depth),
		.letter     (node_letter),
		.query_low  (query_low_q),
		.query_high (query_high_q),
		.query_len  (query_len_q),
		.out_free   (out_free),
		.rd_data    (rd_data),
		.busy       (busy),
		.load       (load),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.ctrl       (ctrl),
		.prev_val   (prev_val)
	);

	tlrs_col_unit u_col (
		.clk      (clk),
		.ctrl     (ctrl),
		.prev_val (prev_val),
		.col_val  (col_val),
		.curr_q   (curr_val),
		.min_q    (min_val)
	);

	tlrs_ram #(
		.WIDTH (tlrs_pkg::VAL_W),
		.DEPTH (tlrs_pkg::STACK_DEPTH)
	) u_row_stack (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (col_val),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

`ifndef SYNTHESIS
	// parent row and new row never overlap
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("row stack read and write hit the same entry");

	// the row minimum can never exceed the last column
	a_min_le_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (row_minimum <= edit_distance))
		else $error("row minimum above last column");

	// a new result only appears after the sequencer hands one off
	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(load))
		else $error("result valid without a hand-off");

	// no node is taken while a row is still being built
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.step || load) |-> !start)
		else $error("node accepted while busy");
`endif

endmodule
